// ===== rtl/lrbe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbe_pkg: shared types and constants for the rate estimator
// Word layouts, request and register codes, controller states, the
// command and status groups between controller and datapath, and the
// fixed thresholds and Q16 multipliers of the report tiers.
// ----------------------------------------------------------------------------
package lrbe_pkg;

    // Field widths
    localparam int RATE_W  = 20;
    localparam int RTT_W   = 16;
    localparam int FRAC_W  = 8;
    localparam int BYTES_W = 16;
    localparam int WIN_W   = 16;
    localparam int MS_W    = 20;
    localparam int CFG_W   = 20;
    localparam int CIDX_W  = 2;
    localparam int Q16_W   = 17;
    localparam int PROD_W  = RATE_W + Q16_W;

    localparam int BYTE_TOTAL_WIDTH_DEF = 32;

    // Register reset values
    localparam logic [RATE_W-1:0] MIN_RATE_RST   = 20'd100;
    localparam logic [RATE_W-1:0] MAX_RATE_RST   = 20'd4000;
    localparam logic [RATE_W-1:0] START_RATE_RST = 20'd1000;
    localparam logic [WIN_W-1:0]  WINDOW_RST     = 16'd1000;
    localparam logic [WIN_W-1:0]  MIN_WINDOW     = 16'd100;

    // Report tier thresholds
    localparam logic [FRAC_W-1:0] FRAC_HEAVY  = 8'd77;
    localparam logic [FRAC_W-1:0] FRAC_MID    = 8'd39;
    localparam logic [FRAC_W-1:0] FRAC_LIGHT  = 8'd13;
    localparam logic [FRAC_W-1:0] FRAC_GOOD   = 8'd5;
    localparam logic [RTT_W-1:0]  RTT_HEAVY   = 16'd800;
    localparam logic [RTT_W-1:0]  RTT_MID     = 16'd500;
    localparam logic [RTT_W-1:0]  RTT_LIGHT   = 16'd300;
    localparam logic [RTT_W-1:0]  RTT_GOOD    = 16'd120;

    // Q16 rate multipliers, truncated
    localparam logic [Q16_W-1:0] MUL_050   = 17'd32768;
    localparam logic [Q16_W-1:0] MUL_070   = 17'd45875;
    localparam logic [Q16_W-1:0] MUL_085   = 17'd55705;
    localparam logic [Q16_W-1:0] MUL_108   = 17'd70778;
    localparam logic [Q16_W-1:0] MUL_UNITY = 17'd65536;

    typedef enum logic [1:0] {
        REQ_TICK   = 2'd0,
        REQ_SENT   = 2'd1,
        REQ_REPORT = 2'd2,
        REQ_QUERY  = 2'd3
    } t_req_type;

    typedef enum logic [CIDX_W-1:0] {
        CFG_MIN_RATE   = 2'd0,
        CFG_MAX_RATE   = 2'd1,
        CFG_START_RATE = 2'd2,
        CFG_WINDOW     = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_TICK,
        ST_DIV,
        ST_APPLY,
        ST_ADD,
        ST_MUL,
        ST_SCALE,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [BYTES_W-1:0] byte_count;
        logic [FRAC_W-1:0]  fraction_lost;
        logic [RTT_W-1:0]   rtt_ms;
    } t_in_word;

    typedef struct packed {
        logic [RATE_W-1:0] bitrate_kbps;
        logic [RTT_W-1:0]  current_rtt_ms;
        logic [FRAC_W-1:0] current_fraction_lost;
    } t_out_word;

    typedef struct packed {
        logic load_in;
        logic tick;
        logic div_start;
        logic apply;
        logic add;
        logic mul;
        logic scale;
        logic load_out;
    } t_ctrl_cmd;

    typedef struct packed {
        t_req_type req_type;
        logic      refresh_due;
        logic      div_done;
        logic      reload_busy;
    } t_ctrl_stat;

endpackage

// ===== rtl/loss_rtt_bitrate_estimator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// loss_rtt_bitrate_estimator_core: loss and RTT driven send-rate estimator
// Keeps a kbps estimate from sent bytes per window and receiver reports.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready, i_in_word) takes one word per
//   request: tick, packet sent, receiver report or query. Each word yields
//   exactly one result word on the output channel (o_out_valid /
//   i_out_ready, o_out_word) carrying the estimate after that request.
//   Words are handled one at a time. A query with no window refresh goes
//   straight to the output; a tick advances the window time, a packet
//   adds its bytes and a report scales the rate by its loss/RTT tier. A
//   query or packet that finds the window due first runs the bit-serial
//   divider, one quotient bit per cycle over BYTE_TOTAL_WIDTH+3 dividend
//   bits, and applies the measured rate. After a result is loaded the
//   controller returns to idle, where the next word can be taken. The
//   result sits in an output register; a stalled receiver holds it, and
//   the next word is accepted meanwhile, waiting only to hand over its
//   own result. Configuration (i_cfg_valid, index, data) is written while
//   idle; each write reloads the estimate with the clamped start rate, and
//   no input word is taken while the reload is under way. After reset the
//   registers hold their defaults and the start rate is loaded before any input.
// ----------------------------------------------------------------------------
module loss_rtt_bitrate_estimator_core #(
    parameter int BYTE_TOTAL_WIDTH = lrbe_pkg::BYTE_TOTAL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  lrbe_pkg::t_in_word          i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output lrbe_pkg::t_out_word         o_out_word,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [lrbe_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [lrbe_pkg::CFG_W-1:0]  i_cfg_data
);

    lrbe_pkg::t_ctrl_cmd  w_cmd;
    lrbe_pkg::t_ctrl_stat w_stat;

    // Configuration writes are always accepted
    assign o_cfg_ready = 1'b1;

    // Sequencer
    lrbe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Datapath
    lrbe_dp #(
        .BYTE_TOTAL_WIDTH (BYTE_TOTAL_WIDTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_word  (o_out_word)
    );

endmodule

// ===== rtl/lrbe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbe_div: bit-serial restoring divider
// Unsigned DW-bit dividend over a 20-bit nonzero divisor, one quotient
// bit per cycle; pulses o_done when the quotient is ready.
// ----------------------------------------------------------------------------
module lrbe_div #(
    parameter int DW = lrbe_pkg::BYTE_TOTAL_WIDTH_DEF + 3
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [DW-1:0]             i_dividend,
    input  logic [lrbe_pkg::MS_W-1:0] i_divisor,
    output logic                      o_done,
    output logic [DW-1:0]             o_quotient
);

    localparam int CW = $clog2(DW);
    localparam int MW = lrbe_pkg::MS_W;

    logic [DW-1:0] r_q;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_dvsr;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [MW:0]   w_trial;
    logic [MW:0]   w_diff;
    logic          w_fit;

    // Trial subtract of the shifted remainder
    assign w_trial = {r_rem, r_q[DW-1]};
    assign w_fit   = w_trial >= {1'b0, r_dvsr};
    assign w_diff  = w_trial - {1'b0, r_dvsr};

    // Step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Shift quotient bits in, keep the partial remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q    <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DW-2:0], w_fit};
            r_rem <= w_fit ? w_diff[MW-1:0] : w_trial[MW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

// ===== rtl/lrbe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbe_dp: estimator datapath
// Configuration registers, rate and window state, the report multiplier,
// the throughput divider and the result register, all stepped by
// commands from the controller.
// ----------------------------------------------------------------------------
module lrbe_dp #(
    parameter int BYTE_TOTAL_WIDTH = lrbe_pkg::BYTE_TOTAL_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  lrbe_pkg::t_in_word          i_in_word,
    input  logic                        i_cfg_valid,
    input  logic [lrbe_pkg::CIDX_W-1:0] i_cfg_index,
    input  logic [lrbe_pkg::CFG_W-1:0]  i_cfg_data,
    input  lrbe_pkg::t_ctrl_cmd         i_cmd,
    output lrbe_pkg::t_ctrl_stat        o_stat,
    output lrbe_pkg::t_out_word         o_out_word
);

    localparam int BW = BYTE_TOTAL_WIDTH;
    localparam int DW = BW + 3;
    localparam int RW = lrbe_pkg::RATE_W;
    localparam int PW = lrbe_pkg::PROD_W;

    // Configuration and state
    logic [RW-1:0]                r_min;
    logic [RW-1:0]                r_max;
    logic [RW-1:0]                r_start;
    logic [lrbe_pkg::WIN_W-1:0]   r_win;
    logic                         r_reload;
    logic [RW-1:0]                r_rate;
    logic [BW-1:0]                r_bytes;
    logic [lrbe_pkg::MS_W-1:0]    r_ms;
    logic [lrbe_pkg::RTT_W-1:0]   r_rtt;
    logic [lrbe_pkg::FRAC_W-1:0]  r_frac;
    lrbe_pkg::t_in_word           r_in;
    logic [PW-1:0]                r_prod;
    lrbe_pkg::t_out_word          r_out;

    logic [RW-1:0]                w_eff_min;
    logic [RW-1:0]                w_eff_max;
    logic [lrbe_pkg::WIN_W-1:0]   w_eff_win;
    logic [RW-1:0]                w_start_clamped;
    logic [DW-1:0]                w_quot;
    logic                         w_div_done;
    logic [RW-1:0]                w_quot_clamped;
    logic [RW:0]                  w_scaled;
    logic [RW-1:0]                w_scaled_clamped;
    logic [lrbe_pkg::Q16_W-1:0]   w_mul;
    logic [BW:0]                  w_sum;

    // Normalize the configuration
    assign w_eff_min = (r_min == '0) ? RW'(1) : r_min;
    assign w_eff_max = (r_max < w_eff_min) ? w_eff_min : r_max;
    assign w_eff_win = (r_win < lrbe_pkg::MIN_WINDOW) ? lrbe_pkg::MIN_WINDOW : r_win;

    assign w_start_clamped = (r_start > w_eff_max) ? w_eff_max :
                             (r_start < w_eff_min) ? w_eff_min : r_start;

    // Throughput divider: bytes * 8 over elapsed ms
    lrbe_div #(
        .DW (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({r_bytes, 3'b000}),
        .i_divisor  (r_ms),
        .o_done     (w_div_done),
        .o_quotient (w_quot)
    );

    assign w_quot_clamped = (w_quot > DW'(w_eff_max)) ? w_eff_max :
                            (w_quot < DW'(w_eff_min)) ? w_eff_min : w_quot[RW-1:0];

    // Pick the report tier multiplier
    always_comb begin
        if (r_in.fraction_lost >= lrbe_pkg::FRAC_HEAVY || r_in.rtt_ms > lrbe_pkg::RTT_HEAVY) begin
            w_mul = lrbe_pkg::MUL_050;
        end else if (r_in.fraction_lost >= lrbe_pkg::FRAC_MID
                     || r_in.rtt_ms > lrbe_pkg::RTT_MID) begin
            w_mul = lrbe_pkg::MUL_070;
        end else if (r_in.fraction_lost >= lrbe_pkg::FRAC_LIGHT
                     || r_in.rtt_ms > lrbe_pkg::RTT_LIGHT) begin
            w_mul = lrbe_pkg::MUL_085;
        end else if (r_in.fraction_lost <= lrbe_pkg::FRAC_GOOD
                     && r_in.rtt_ms < lrbe_pkg::RTT_GOOD) begin
            w_mul = lrbe_pkg::MUL_108;
        end else begin
            w_mul = lrbe_pkg::MUL_UNITY;
        end
    end

    assign w_scaled         = r_prod[PW-1:16];
    assign w_scaled_clamped = (w_scaled > {1'b0, w_eff_max}) ? w_eff_max :
                              (w_scaled < {1'b0, w_eff_min}) ? w_eff_min : w_scaled[RW-1:0];

    // Saturating byte accumulate
    assign w_sum = {1'b0, r_bytes} + (BW + 1)'(r_in.byte_count);

    // Configuration registers; any write reloads the rate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min    <= lrbe_pkg::MIN_RATE_RST;
            r_max    <= lrbe_pkg::MAX_RATE_RST;
            r_start  <= lrbe_pkg::START_RATE_RST;
            r_win    <= lrbe_pkg::WINDOW_RST;
            r_reload <= 1'b1;
        end else begin
            r_reload <= 1'b0;
            if (i_cfg_valid) begin
                r_reload <= 1'b1;
                unique case (lrbe_pkg::t_cfg_idx'(i_cfg_index))
                    lrbe_pkg::CFG_MIN_RATE:   r_min   <= i_cfg_data;
                    lrbe_pkg::CFG_MAX_RATE:   r_max   <= i_cfg_data;
                    lrbe_pkg::CFG_START_RATE: r_start <= i_cfg_data;
                    lrbe_pkg::CFG_WINDOW:     r_win   <= i_cfg_data[lrbe_pkg::WIN_W-1:0];
                endcase
            end
        end
    end

    // Rate estimate
    always_ff @(posedge i_clk) begin
        if (r_reload) begin
            r_rate <= w_start_clamped;
        end else if (i_cmd.apply && w_quot != '0) begin
            r_rate <= w_quot_clamped;
        end else if (i_cmd.scale) begin
            r_rate <= w_scaled_clamped;
        end
    end

    // Window and report state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes <= '0;
            r_ms    <= '0;
            r_rtt   <= '0;
            r_frac  <= '0;
        end else begin
            if (i_cmd.tick && r_ms != '1) begin
                r_ms <= r_ms + 1'b1;
            end
            if (i_cmd.apply) begin
                r_ms    <= '0;
                r_bytes <= '0;
            end
            if (i_cmd.add) begin
                r_bytes <= w_sum[BW] ? '1 : w_sum[BW-1:0];
            end
            if (i_cmd.mul) begin
                r_rtt  <= r_in.rtt_ms;
                r_frac <= r_in.fraction_lost;
            end
        end
    end

    // Capture input word, product and result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_in_word;
        end
        if (i_cmd.mul) begin
            r_prod <= PW'(r_rate) * PW'(w_mul);
        end
        if (i_cmd.load_out) begin
            r_out.bitrate_kbps          <= r_rate;
            r_out.current_rtt_ms        <= r_rtt;
            r_out.current_fraction_lost <= r_frac;
        end
    end

    // Status to the controller
    assign o_stat.req_type    = lrbe_pkg::t_req_type'(r_in.req_type);
    assign o_stat.refresh_due = r_ms >= lrbe_pkg::MS_W'(w_eff_win);
    assign o_stat.div_done    = w_div_done;
    assign o_stat.reload_busy = r_reload;

    assign o_out_word = r_out;

endmodule

// ===== rtl/lrbe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrbe_ctrl: estimator sequencer
// Takes one input word at a time, walks the datapath through the steps
// of its request kind and hands the result to the output register.
// ----------------------------------------------------------------------------
module lrbe_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  lrbe_pkg::t_ctrl_stat i_stat,
    output lrbe_pkg::t_ctrl_cmd  o_cmd
);

    lrbe_pkg::t_state r_state;
    lrbe_pkg::t_state n_state;
    logic             r_out_valid;

    // State register and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lrbe_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = (r_state == lrbe_pkg::ST_IDLE) && !i_stat.reload_busy;
        unique case (r_state)
            lrbe_pkg::ST_IDLE: begin
                if (i_in_valid && o_in_ready) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = lrbe_pkg::ST_DECODE;
                end
            end
            lrbe_pkg::ST_DECODE: begin
                unique case (i_stat.req_type) inside
                    lrbe_pkg::REQ_TICK:   n_state = lrbe_pkg::ST_TICK;
                    lrbe_pkg::REQ_REPORT: n_state = lrbe_pkg::ST_MUL;
                    lrbe_pkg::REQ_SENT, lrbe_pkg::REQ_QUERY: begin
                        if (i_stat.refresh_due) begin
                            o_cmd.div_start = 1'b1;
                            n_state         = lrbe_pkg::ST_DIV;
                        end else if (i_stat.req_type == lrbe_pkg::REQ_SENT) begin
                            n_state = lrbe_pkg::ST_ADD;
                        end else begin
                            n_state = lrbe_pkg::ST_OUT;
                        end
                    end
                endcase
            end
            lrbe_pkg::ST_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = lrbe_pkg::ST_OUT;
            end
            lrbe_pkg::ST_DIV: begin
                if (i_stat.div_done) begin
                    n_state = lrbe_pkg::ST_APPLY;
                end
            end
            lrbe_pkg::ST_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = (i_stat.req_type == lrbe_pkg::REQ_SENT) ?
                              lrbe_pkg::ST_ADD : lrbe_pkg::ST_OUT;
            end
            lrbe_pkg::ST_ADD: begin
                o_cmd.add = 1'b1;
                n_state   = lrbe_pkg::ST_OUT;
            end
            lrbe_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = lrbe_pkg::ST_SCALE;
            end
            lrbe_pkg::ST_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = lrbe_pkg::ST_OUT;
            end
            lrbe_pkg::ST_OUT: begin
                // hold until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = lrbe_pkg::ST_IDLE;
                end
            end
            default: n_state = lrbe_pkg::ST_IDLE;
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for loss_rtt_bitrate_estimator_core
// A queue-fed driver sends request words in random bursts, and a monitor
// checks every result word against an in-bench rate estimator that tracks
// window, report and clamp state. Register settings change between phases
// while the core is idle, and the receiver stalls on a rotating pattern.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int          BYTE_TOTAL_W = lrbe_pkg::BYTE_TOTAL_WIDTH_DEF;
    localparam logic [63:0] BYTE_SAT     = (64'd1 << BYTE_TOTAL_W) - 64'd1;
    localparam logic [lrbe_pkg::MS_W-1:0] MS_SAT = '1;
    localparam int          CYCLE_LIMIT  = 1000000;
    localparam int          SETTLE_CYCLES = 64;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_ready;
    lrbe_pkg::t_in_word            i_in_word = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b1;
    lrbe_pkg::t_out_word           o_out_word;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [lrbe_pkg::CIDX_W-1:0]   i_cfg_index = '0;
    logic [lrbe_pkg::CFG_W-1:0]    i_cfg_data = '0;

    // Request words waiting to go out, and estimates waiting to come back
    lrbe_pkg::t_in_word  pending_requests[$];
    lrbe_pkg::t_out_word expected_estimates[$];

    // Estimator state as the bench sees it
    logic [lrbe_pkg::RATE_W-1:0] cfg_min_rate;
    logic [lrbe_pkg::RATE_W-1:0] cfg_max_rate;
    logic [lrbe_pkg::RATE_W-1:0] cfg_start_rate;
    logic [lrbe_pkg::WIN_W-1:0]  cfg_window;
    logic [lrbe_pkg::RATE_W-1:0] est_rate;
    logic [63:0]                 win_bytes;
    logic [lrbe_pkg::MS_W-1:0]   win_ms;
    logic [lrbe_pkg::RTT_W-1:0]  last_rtt;
    logic [lrbe_pkg::FRAC_W-1:0] last_frac;

    int unsigned cycle_count = 0;
    int          error_count = 0;
    int          burst_left = 0;
    int          gap_left = 0;

    loss_rtt_bitrate_estimator_core #(
        .BYTE_TOTAL_WIDTH(BYTE_TOTAL_W)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Clamp a wide value into the normalized min..max range
    function automatic logic [lrbe_pkg::RATE_W-1:0] clamp_to_range(logic [63:0] v);
        logic [lrbe_pkg::RATE_W-1:0] lo;
        logic [lrbe_pkg::RATE_W-1:0] hi;
        lo = (cfg_min_rate == '0) ? 20'd1 : cfg_min_rate;
        hi = (cfg_max_rate < lo) ? lo : cfg_max_rate;
        if (v > {44'd0, hi}) return hi;
        if (v < {44'd0, lo}) return lo;
        return v[lrbe_pkg::RATE_W-1:0];
    endfunction

    // Replace the rate by measured throughput once the window has run out
    function automatic void refresh_window();
        logic [lrbe_pkg::WIN_W-1:0] span;
        logic [63:0]                kbps;
        span = (cfg_window < lrbe_pkg::MIN_WINDOW) ? lrbe_pkg::MIN_WINDOW : cfg_window;
        if (win_ms < {4'd0, span}) return;
        kbps = (win_bytes * 64'd8) / {44'd0, win_ms};
        if (kbps != 64'd0) est_rate = clamp_to_range(kbps);
        win_ms = '0;
        win_bytes = '0;
    endfunction

    // Advance the estimator by one request and return the estimate word
    function automatic lrbe_pkg::t_out_word predict_estimate(lrbe_pkg::t_in_word w);
        logic [63:0]         scaled;
        lrbe_pkg::t_out_word r;
        case (lrbe_pkg::t_req_type'(w.req_type))
            lrbe_pkg::REQ_TICK: begin
                if (win_ms != MS_SAT) win_ms = win_ms + 1'b1;
            end
            lrbe_pkg::REQ_SENT: begin
                refresh_window();
                if ({48'd0, w.byte_count} > BYTE_SAT - win_bytes) win_bytes = BYTE_SAT;
                else win_bytes = win_bytes + {48'd0, w.byte_count};
            end
            lrbe_pkg::REQ_REPORT: begin
                last_frac = w.fraction_lost;
                last_rtt = w.rtt_ms;
                scaled = {44'd0, est_rate};
                if (w.fraction_lost >= lrbe_pkg::FRAC_HEAVY || w.rtt_ms > lrbe_pkg::RTT_HEAVY)
                    scaled = (scaled * lrbe_pkg::MUL_050) >> 16;
                else if (w.fraction_lost >= lrbe_pkg::FRAC_MID ||
                         w.rtt_ms > lrbe_pkg::RTT_MID)
                    scaled = (scaled * lrbe_pkg::MUL_070) >> 16;
                else if (w.fraction_lost >= lrbe_pkg::FRAC_LIGHT ||
                         w.rtt_ms > lrbe_pkg::RTT_LIGHT)
                    scaled = (scaled * lrbe_pkg::MUL_085) >> 16;
                else if (w.fraction_lost <= lrbe_pkg::FRAC_GOOD &&
                         w.rtt_ms < lrbe_pkg::RTT_GOOD)
                    scaled = (scaled * lrbe_pkg::MUL_108) >> 16;
                est_rate = clamp_to_range(scaled);
            end
            default: begin
                refresh_window();
            end
        endcase
        r.bitrate_kbps = est_rate;
        r.current_rtt_ms = last_rtt;
        r.current_fraction_lost = last_frac;
        return r;
    endfunction

    function automatic lrbe_pkg::t_in_word make_request(lrbe_pkg::t_req_type kind,
                                                        logic [lrbe_pkg::BYTES_W-1:0] nbytes,
                                                        logic [lrbe_pkg::FRAC_W-1:0] frac,
                                                        logic [lrbe_pkg::RTT_W-1:0] rtt);
        lrbe_pkg::t_in_word w;
        w.req_type = kind;
        w.byte_count = nbytes;
        w.fraction_lost = frac;
        w.rtt_ms = rtt;
        return w;
    endfunction

    // Random request; unused fields carry noise, reports lean on tier edges
    function automatic lrbe_pkg::t_in_word random_request(int sent_pct, int report_pct,
                                                          bit tiny_packets);
        lrbe_pkg::t_in_word w;
        int                 roll;
        w.byte_count = lrbe_pkg::BYTES_W'($urandom);
        w.fraction_lost = lrbe_pkg::FRAC_W'($urandom);
        w.rtt_ms = lrbe_pkg::RTT_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < sent_pct) begin
            w.req_type = lrbe_pkg::REQ_SENT;
            case ($urandom_range(0, 3))
                0: w.byte_count = lrbe_pkg::BYTES_W'($urandom_range(0, 3));
                1: w.byte_count = lrbe_pkg::BYTES_W'(32'hFFFF - $urandom_range(0, 15));
                default: ;
            endcase
            if (tiny_packets) w.byte_count = lrbe_pkg::BYTES_W'($urandom_range(0, 2));
        end else if (roll < sent_pct + report_pct) begin
            w.req_type = lrbe_pkg::REQ_REPORT;
            case ($urandom_range(0, 11))
                0: w.fraction_lost = '0;
                1: w.fraction_lost = lrbe_pkg::FRAC_GOOD;
                2: w.fraction_lost = lrbe_pkg::FRAC_GOOD + 1'b1;
                3: w.fraction_lost = lrbe_pkg::FRAC_LIGHT - 1'b1;
                4: w.fraction_lost = lrbe_pkg::FRAC_LIGHT;
                5: w.fraction_lost = lrbe_pkg::FRAC_MID - 1'b1;
                6: w.fraction_lost = lrbe_pkg::FRAC_MID;
                7: w.fraction_lost = lrbe_pkg::FRAC_HEAVY - 1'b1;
                8: w.fraction_lost = lrbe_pkg::FRAC_HEAVY;
                9: w.fraction_lost = lrbe_pkg::FRAC_W'($urandom_range(0, lrbe_pkg::FRAC_GOOD));
                default: ;
            endcase
            case ($urandom_range(0, 11))
                0: w.rtt_ms = lrbe_pkg::RTT_GOOD - 1'b1;
                1: w.rtt_ms = lrbe_pkg::RTT_GOOD;
                2: w.rtt_ms = lrbe_pkg::RTT_LIGHT;
                3: w.rtt_ms = lrbe_pkg::RTT_LIGHT + 1'b1;
                4: w.rtt_ms = lrbe_pkg::RTT_MID;
                5: w.rtt_ms = lrbe_pkg::RTT_MID + 1'b1;
                6: w.rtt_ms = lrbe_pkg::RTT_HEAVY;
                7: w.rtt_ms = lrbe_pkg::RTT_HEAVY + 1'b1;
                8, 9: w.rtt_ms = lrbe_pkg::RTT_W'($urandom_range(0, lrbe_pkg::RTT_GOOD - 1));
                default: ;
            endcase
        end else if (roll < sent_pct + report_pct + 4) begin
            w.req_type = lrbe_pkg::REQ_QUERY;
        end else begin
            w.req_type = lrbe_pkg::REQ_TICK;
        end
        return w;
    endfunction

    // Write one register while idle and reload the bench estimator
    task automatic write_register(lrbe_pkg::t_cfg_idx idx, logic [lrbe_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            lrbe_pkg::CFG_MIN_RATE:   cfg_min_rate = value;
            lrbe_pkg::CFG_MAX_RATE:   cfg_max_rate = value;
            lrbe_pkg::CFG_START_RATE: cfg_start_rate = value;
            default:                  cfg_window = value[lrbe_pkg::WIN_W-1:0];
        endcase
        est_rate = clamp_to_range({44'd0, cfg_start_rate});
        i_cfg_valid <= 1'b0;
    endtask

    // Hold until every request is out and every estimate is back, then settle
    task automatic wait_idle();
        while (pending_requests.size() != 0 || i_in_valid || expected_estimates.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_ticks(int count);
        for (int k = 0; k < count; k++)
            pending_requests.push_back(make_request(lrbe_pkg::REQ_TICK,
                                                    lrbe_pkg::BYTES_W'($urandom),
                                                    lrbe_pkg::FRAC_W'($urandom),
                                                    lrbe_pkg::RTT_W'($urandom)));
    endtask

    task automatic run_phase(logic [lrbe_pkg::CFG_W-1:0] min_rate,
                             logic [lrbe_pkg::CFG_W-1:0] max_rate,
                             logic [lrbe_pkg::CFG_W-1:0] start_rate,
                             logic [lrbe_pkg::CFG_W-1:0] window,
                             int count, int sent_pct, int report_pct, bit tiny_packets);
        wait_idle();
        write_register(lrbe_pkg::CFG_MIN_RATE, min_rate);
        write_register(lrbe_pkg::CFG_MAX_RATE, max_rate);
        write_register(lrbe_pkg::CFG_WINDOW, window);
        write_register(lrbe_pkg::CFG_START_RATE, start_rate);
        for (int k = 0; k < count; k++)
            pending_requests.push_back(random_request(sent_pct, report_pct, tiny_packets));
    endtask

    // Stimulus and end of run
    initial begin
        cfg_min_rate = lrbe_pkg::MIN_RATE_RST;
        cfg_max_rate = lrbe_pkg::MAX_RATE_RST;
        cfg_start_rate = lrbe_pkg::START_RATE_RST;
        cfg_window = lrbe_pkg::WINDOW_RST;
        est_rate = clamp_to_range({44'd0, lrbe_pkg::START_RATE_RST});
        win_bytes = '0;
        win_ms = '0;
        last_rtt = '0;
        last_frac = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every tier and its edges, field extremes, every request kind
        pending_requests.push_back(make_request(lrbe_pkg::REQ_QUERY, '0, '0, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, lrbe_pkg::FRAC_GOOD,
                                                lrbe_pkg::RTT_GOOD - 1'b1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0,
                                                lrbe_pkg::FRAC_HEAVY, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0,
                                                lrbe_pkg::FRAC_HEAVY - 1'b1,
                                                lrbe_pkg::RTT_HEAVY + 1'b1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0,
                                                lrbe_pkg::FRAC_MID, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '0,
                                                lrbe_pkg::RTT_MID + 1'b1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '0,
                                                lrbe_pkg::RTT_HEAVY));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0,
                                                lrbe_pkg::FRAC_LIGHT, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '0,
                                                lrbe_pkg::RTT_LIGHT + 1'b1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '0,
                                                lrbe_pkg::RTT_LIGHT));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0,
                                                lrbe_pkg::FRAC_GOOD + 1'b1, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '0,
                                                lrbe_pkg::RTT_GOOD));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '1, '1, '1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '1, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '1, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '0, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_SENT, '0, '1, '1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_SENT, '1, '0, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_TICK, '1, '1, '1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_TICK, '0, '0, '0));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_QUERY, '1, '1, '1));
        pending_requests.push_back(make_request(lrbe_pkg::REQ_REPORT, '0, '0, '0));

        // Random phases over several register settings, extremes among them
        run_phase(20'd0, 20'hFFFFF, 20'd0, 20'd0, 130, 8, 6, 1'b0);
        run_phase(20'd100, 20'd4000, 20'd1000, 20'd100, 130, 10, 4, 1'b1);
        run_phase(20'd5000, 20'd20, 20'hFFFFF, 20'd99, 130, 8, 8, 1'b0);
        run_phase(20'hFFFFF, 20'hFFFFF, 20'd0, 20'd101, 130, 8, 5, 1'b0);
        run_phase(20'd0, 20'd0, 20'd0, 20'hFFFF, 120, 10, 10, 1'b0);
        run_phase(20'd20000, 20'hFFFFF, 20'hFFFFF, 20'd150, 130, 12, 6, 1'b0);
        run_phase(20'd1, 20'd300, 20'd250, 20'd100, 130, 6, 10, 1'b0);

        // Flood one window so the measured rate overflows the rate width
        push_ticks(100);
        for (int k = 0; k < 210; k++)
            pending_requests.push_back(make_request(lrbe_pkg::REQ_SENT, '1,
                                                    lrbe_pkg::FRAC_W'($urandom),
                                                    lrbe_pkg::RTT_W'($urandom)));
        push_ticks(100);
        pending_requests.push_back(make_request(lrbe_pkg::REQ_QUERY, '0, '0, '0));

        wait_idle();
        if (error_count == 0 && expected_estimates.size() == 0) begin
            $display("loss_rtt_bitrate_estimator_core verification clean");
        end else begin
            $display("loss_rtt_bitrate_estimator_core verification failed");
        end
        $finish;
    end

    // Driver: send pending words in bursts, predict each word as it is taken
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                expected_estimates.push_back(predict_estimate(i_in_word));
                void'(pending_requests.pop_front());
            end
            if (i_in_valid && !o_in_ready) begin
                // hold the word until taken
            end else if (gap_left != 0) begin
                gap_left--;
                i_in_valid <= 1'b0;
            end else if (pending_requests.size() != 0) begin
                i_in_valid <= 1'b1;
                i_in_word <= pending_requests[0];
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    case ($urandom_range(0, 3))
                        0: gap_left = 0;
                        1: gap_left = $urandom_range(1, 3);
                        2: gap_left = $urandom_range(4, 20);
                        default: gap_left = $urandom_range(20, 60);
                    endcase
                end else begin
                    burst_left--;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Receiver: rotate through free-flowing, random and periodic stalls
    always @(posedge i_clk) begin
        case (cycle_count[10:9])
            2'd0:    i_out_ready <= 1'b1;
            2'd1:    i_out_ready <= ($urandom_range(0, 1) == 0);
            2'd2:    i_out_ready <= ($urandom_range(0, 5) == 0);
            default: i_out_ready <= (cycle_count[2:0] != 3'd5);
        endcase
    end

    // Monitor: compare each taken estimate with the oldest expected one
    always @(posedge i_clk) begin : check_estimates
        lrbe_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_estimates.size() == 0) begin
                error_count++;
                if (error_count <= 10)
                    $display("ERROR: unexpected result word rate=%0d rtt=%0d frac=%0d",
                             o_out_word.bitrate_kbps, o_out_word.current_rtt_ms,
                             o_out_word.current_fraction_lost);
            end else begin
                want = expected_estimates.pop_front();
                if (o_out_word.bitrate_kbps !== want.bitrate_kbps ||
                    o_out_word.current_rtt_ms !== want.current_rtt_ms ||
                    o_out_word.current_fraction_lost !== want.current_fraction_lost) begin
                    error_count++;
                    if (error_count <= 10)
                        $display("ERROR: rate %0d/%0d rtt %0d/%0d frac %0d/%0d (exp/got)",
                                 want.bitrate_kbps, o_out_word.bitrate_kbps,
                                 want.current_rtt_ms, o_out_word.current_rtt_ms,
                                 want.current_fraction_lost,
                                 o_out_word.current_fraction_lost);
                end
            end
        end
    end

    // Watchdog: end the run if it never drains
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("loss_rtt_bitrate_estimator_core verification failed");
            $finish;
        end
    end

endmodule

// ===== loss_rtt_bitrate_estimator_core.f =====
rtl/lrbe_pkg.sv
rtl/lrbe_div.sv
rtl/lrbe_dp.sv
rtl/lrbe_ctrl.sv
rtl/loss_rtt_bitrate_estimator_core.sv
tb/tb_top.sv
